// ----- src/bcbh_pkg.sv -----
// ----------------------------------------------------------------------------
// bcbh_pkg
// Shared widths, register codes and reset values of the block hash.
// ----------------------------------------------------------------------------
package bcbh_pkg;

    localparam int ID_WIDTH_DEF = 64;
    localparam int CODE_W       = 63;
    localparam int HASH_W       = 63;
    localparam int IDX_W        = 6;
    localparam int LEN_W        = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 6;
    localparam int SEL_DEPTH    = 64;
    localparam int SEL_W        = 7;

    localparam logic [LEN_W-1:0] CODE_LENGTH_RST = 6'd32;
    localparam logic [LEN_W-1:0] BLOCK_PARAM_RST = 6'd8;
    localparam logic             SKIP_MODE_RST   = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CODE_LENGTH = 2'd0,
        REG_BLOCK_PARAM = 2'd1,
        REG_SKIP_MODE   = 2'd2
    } cfg_reg_t;

endpackage

// ----- src/bcbh_in_if.sv -----
// ----------------------------------------------------------------------------
// bcbh_in_if
// Id word channel: valid/ready with the id and its batch mark.
// ----------------------------------------------------------------------------
interface bcbh_in_if #(parameter int ID_WIDTH = bcbh_pkg::ID_WIDTH_DEF);

    logic                valid;
    logic                ready;
    logic [ID_WIDTH-1:0] id_value;
    logic                last_item;

    modport source (output valid, output id_value, output last_item, input ready);
    modport sink   (input valid, input id_value, input last_item, output ready);

endinterface

// ----- src/bcbh_out_if.sv -----
// ----------------------------------------------------------------------------
// bcbh_out_if
// Hash word channel: valid/ready with one block result.
// ----------------------------------------------------------------------------
interface bcbh_out_if;

    logic                          valid;
    logic                          ready;
    logic [bcbh_pkg::HASH_W-1:0]   hash_value;
    logic [bcbh_pkg::IDX_W-1:0]    block_index;
    logic                          last_block;
    logic                          last_of_batch;

    modport source (output valid, output hash_value, output block_index,
                    output last_block, output last_of_batch, input ready);
    modport sink   (input valid, input hash_value, input block_index,
                    input last_block, input last_of_batch, output ready);

endinterface

// ----- src/binary_code_block_hash.sv -----
// ----------------------------------------------------------------------------
// binary_code_block_hash
// Splits the low code bits of an id into blocks and emits one hash word
// per block, in succession (contiguous) or skip (interleaved) order.
//
//   channel   dir  handshake      payload
//   id_ch     in   valid/ready    id_value, last_item
//   hash_ch   out  valid/ready    hash_value, block_index, last_block,
//                                 last_of_batch
//   wr_*      in   wr_en          wr_index, wr_data
//
// One hash word per cycle while hash_ch.ready is high; an id holds the
// block emitter until all its blocks are out (four at 32 bits in 8-bit
// blocks, succession order). Ids pass through 5 stages, s1 to s5.
// After reset and after every register write a sweep over all 64 table
// entries builds the skip stride table; id_ch.ready is low meanwhile.
// Back pressure stalls each stage only when the stage after it is full.
// ----------------------------------------------------------------------------
module binary_code_block_hash #(
    parameter int ID_WIDTH = bcbh_pkg::ID_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [bcbh_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [bcbh_pkg::CFG_DATA_W-1:0] wr_data,
    bcbh_in_if.sink                        id_ch,
    bcbh_out_if.source                     hash_ch
);
    import bcbh_pkg::*;

    localparam logic [SEL_W-1:0] SEL_FULL = SEL_W'(SEL_DEPTH);

    // configuration
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] tpar_reg;
    logic             skip_reg;
    logic [LEN_W-1:0] len_e;
    logic [LEN_W-1:0] t_one;
    logic [LEN_W-1:0] t_e;
    logic [SEL_W-1:0] s_e;

    // stride table sweep
    logic             busy_reg, busy_next;
    logic [LEN_W-1:0] sw_j_reg, sw_j_next;
    logic [SEL_W-1:0] sw_acc_reg, sw_acc_next;
    logic [LEN_W-1:0] blen_reg, blen_next;
    logic [SEL_W:0]   sw_sum;
    logic [SEL_W-1:0] sel_reg [SEL_DEPTH];

    // pipeline
    logic              s1_v_reg, s1_v_next;
    logic              s2_v_reg, s2_v_next;
    logic              s3_v_reg, s3_v_next;
    logic              s4_v_reg, s4_v_next;
    logic              s5_v_reg, s5_v_next;
    logic [IDX_W-1:0]  s2_n_reg, s2_n_next;
    logic [LEN_W-1:0]  s2_pos_reg, s2_pos_next;

    logic [CODE_W-1:0] code1_reg, code2_reg, code3_reg;
    logic              last1_reg, last2_reg;
    logic [LEN_W-1:0]  shamt3_reg;
    logic [IDX_W-1:0]  n3_reg, n4_reg, n5_reg;
    logic              lb3_reg, lb4_reg, lb5_reg;
    logic              lob3_reg, lob4_reg, lob5_reg;
    logic [63:0]       sh4_reg;
    logic [HASH_W-1:0] hash5_reg;

    logic              ld1, ld2, ld3, ld4, ld5;
    logic              in_take, take1, emit2, s2_last;
    logic [63:0]       id_ext;
    logic [63:0]       len_mask;
    logic [63:0]       t_mask;
    logic              id_nonpos;
    logic [CODE_W-1:0] code_in;
    logic [CODE_W-1:0] gat;
    logic [CODE_W-1:0] blk_val;
    logic [LEN_W-1:0]  blen_e;
    logic [HASH_W-1:0] hash_calc;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= CODE_LENGTH_RST;
            tpar_reg <= BLOCK_PARAM_RST;
            skip_reg <= SKIP_MODE_RST;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_CODE_LENGTH: len_reg  <= wr_data;
                REG_BLOCK_PARAM: tpar_reg <= wr_data;
                REG_SKIP_MODE:   skip_reg <= wr_data[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        len_e = (len_reg == '0) ? LEN_W'(1) : len_reg;
        t_one = (tpar_reg == '0) ? LEN_W'(1) : tpar_reg;
        t_e   = (t_one > len_e) ? len_e : t_one;
        s_e   = {1'b0, t_e} + SEL_W'(1);
    end

    // ---------------- stride table sweep ----------------
    // sel_reg[j] = j*(t+1), saturated at SEL_FULL; blen counts entries below L
    always_comb
    begin
        busy_next   = busy_reg;
        sw_j_next   = sw_j_reg;
        sw_acc_next = sw_acc_reg;
        blen_next   = blen_reg;
        sw_sum      = {1'b0, sw_acc_reg} + {1'b0, s_e};
        if (wr_en)
        begin
            busy_next   = 1'b1;
            sw_j_next   = '0;
            sw_acc_next = '0;
            blen_next   = '0;
        end
        else if (busy_reg)
        begin
            sw_j_next   = sw_j_reg + LEN_W'(1);
            sw_acc_next = (sw_sum >= {1'b0, SEL_FULL}) ? SEL_FULL : sw_sum[SEL_W-1:0];
            if (sw_acc_reg < {1'b0, len_e})
            begin
                blen_next = blen_reg + LEN_W'(1);
            end
            if (sw_j_reg == LEN_W'(SEL_DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b1;
            sw_j_reg   <= '0;
            sw_acc_reg <= '0;
            blen_reg   <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            sw_j_reg   <= sw_j_next;
            sw_acc_reg <= sw_acc_next;
            blen_reg   <= blen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !wr_en)
        begin
            sel_reg[sw_j_reg] <= sw_acc_reg;
        end
    end

    // ---------------- stage handshakes ----------------
    always_comb
    begin
        if (skip_reg)
        begin
            s2_last = (s2_n_reg == t_e);
        end
        else
        begin
            s2_last = ({1'b0, s2_pos_reg} + {1'b0, t_e}) >= {1'b0, len_e};
        end
        ld5     = !s5_v_reg || hash_ch.ready;
        ld4     = !s4_v_reg || ld5;
        ld3     = !s3_v_reg || ld4;
        emit2   = s2_v_reg && ld3;
        ld2     = !s2_v_reg || (ld3 && s2_last);
        ld1     = !s1_v_reg || ld2;
        in_take = id_ch.valid && id_ch.ready;
        take1   = s1_v_reg && ld2;

        s1_v_next = ld1 ? in_take  : s1_v_reg;
        s2_v_next = ld2 ? s1_v_reg : s2_v_reg;
        s3_v_next = ld3 ? s2_v_reg : s3_v_reg;
        s4_v_next = ld4 ? s3_v_reg : s4_v_reg;
        s5_v_next = ld5 ? s4_v_reg : s5_v_reg;

        s2_n_next   = s2_n_reg;
        s2_pos_next = s2_pos_reg;
        if (take1)
        begin
            s2_n_next   = '0;
            s2_pos_next = '0;
        end
        else if (emit2 && !s2_last)
        begin
            s2_n_next   = s2_n_reg + IDX_W'(1);
            s2_pos_next = s2_pos_reg + t_e;
        end
    end

    assign id_ch.ready = ld1 && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            s3_v_reg   <= 1'b0;
            s4_v_reg   <= 1'b0;
            s5_v_reg   <= 1'b0;
            s2_n_reg   <= '0;
            s2_pos_reg <= '0;
        end
        else
        begin
            s1_v_reg   <= s1_v_next;
            s2_v_reg   <= s2_v_next;
            s3_v_reg   <= s3_v_next;
            s4_v_reg   <= s4_v_next;
            s5_v_reg   <= s5_v_next;
            s2_n_reg   <= s2_n_next;
            s2_pos_reg <= s2_pos_next;
        end
    end

    // ---------------- stage 1: code extraction ----------------
    always_comb
    begin
        id_ext                 = '0;
        id_ext[ID_WIDTH-1:0]   = id_ch.id_value;
        id_nonpos              = id_ch.id_value[ID_WIDTH-1] || (id_ch.id_value == '0);
        len_mask               = (64'd1 << len_e) - 64'd1;
        code_in                = id_nonpos ? '0 : (id_ext[CODE_W-1:0] & len_mask[CODE_W-1:0]);
    end

    // ---------------- stages 4/5: block value and hash ----------------
    always_comb
    begin
        for (int j = 0; j < CODE_W; j++)
        begin
            gat[j] = sel_reg[j][SEL_W-1] ? 1'b0 : sh4_reg[sel_reg[j][SEL_W-2:0]];
        end
        t_mask    = (64'd1 << t_e) - 64'd1;
        blk_val   = skip_reg ? gat : (sh4_reg[CODE_W-1:0] & t_mask[CODE_W-1:0]);
        blen_e    = skip_reg ? blen_reg : t_e;
        hash_calc = blk_val + (HASH_W'(n4_reg) << blen_e);
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            code1_reg <= code_in;
            last1_reg <= id_ch.last_item;
        end
        if (ld2)
        begin
            code2_reg <= code1_reg;
            last2_reg <= last1_reg;
        end
        if (ld3)
        begin
            code3_reg  <= code2_reg;
            shamt3_reg <= skip_reg ? s2_n_reg : s2_pos_reg;
            n3_reg     <= s2_n_reg;
            lb3_reg    <= s2_last;
            lob3_reg   <= s2_last && last2_reg;
        end
        if (ld4)
        begin
            sh4_reg  <= {1'b0, code3_reg} >> shamt3_reg;
            n4_reg   <= n3_reg;
            lb4_reg  <= lb3_reg;
            lob4_reg <= lob3_reg;
        end
        if (ld5)
        begin
            hash5_reg <= hash_calc;
            n5_reg    <= n4_reg;
            lb5_reg   <= lb4_reg;
            lob5_reg  <= lob4_reg;
        end
    end

    assign hash_ch.valid         = s5_v_reg;
    assign hash_ch.hash_value    = hash5_reg;
    assign hash_ch.block_index   = n5_reg;
    assign hash_ch.last_block    = lb5_reg;
    assign hash_ch.last_of_batch = lob5_reg;

    // ---------------- assertions ----------------
    a_wr_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> busy_reg)
        else $error("register write did not restart the stride sweep");

    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !id_ch.ready)
        else $error("id word taken during stride sweep");

    a_batch_on_last_block: assert property (@(posedge clk) disable iff (!rst_n)
        (hash_ch.valid && hash_ch.last_of_batch) |-> hash_ch.last_block)
        else $error("batch end marked on a non-final block");

    a_skip_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_v_reg && skip_reg) |-> (s2_n_reg <= t_e))
        else $error("skip block index past stride");

    a_succ_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_v_reg && !skip_reg) |-> (s2_pos_reg < len_e))
        else $error("succession block starts past code length");

endmodule
